@@ src/bfactor_line_filter_assert.svh @@
// Assertion macros shared by the line filter RTL.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef BFACTOR_LINE_FILTER_ASSERT_SVH
`define BFACTOR_LINE_FILTER_ASSERT_SVH

// Condition that holds at every clock edge out of reset.
`define BFLF_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Consequence in the same cycle as the antecedent.
`define BFLF_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence in the cycle after the antecedent.
`define BFLF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/bflf_pkg.sv @@
// Types and constants of the line filter.
// No dependencies; used by bflf_line_state and bfactor_line_filter.
package bflf_pkg;

	localparam logic [15:0] COL_START    = 16'd60;
	localparam logic [15:0] MIN_LONG_LEN = 16'd66;
	localparam logic [15:0] COL_MAX      = 16'hFFFF;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	// record names in columns 0-3: "ATOM" and "HETA"
	localparam logic [7:0] PAT_ATOM [4] = '{8'h41, 8'h54, 8'h4F, 8'h4D};
	localparam logic [7:0] PAT_HETA [4] = '{8'h48, 8'h45, 8'h54, 8'h41};

	// powers of ten up to the largest fraction width; zero past it
	localparam logic [16:0] POW10 [8] = '{17'd1, 17'd10, 17'd100, 17'd1000, 17'd10000,
		17'd0, 17'd0, 17'd0};

	typedef enum logic [2:0] {
		PH_WAIT,
		PH_LEAD,
		PH_SIGNED,
		PH_INT,
		PH_FRAC,
		PH_DONE
	} phase_t;

	// line summary handed from the parser to the decision stage
	typedef struct packed {
		logic [15:0] col;
		logic [1:0]  match;
		logic        negative;
		logic        dropped;
	} line_info_t;

endpackage

@@ src/bfactor_line_filter.sv @@
// Top level of the line filter: handshakes, line decision and result register.
// Depends on bflf_pkg, bflf_line_state and bfactor_line_filter_assert.svh.
`include "bfactor_line_filter_assert.svh"

// Takes one text byte per clock while in_stall is low and returns one result per
// line (at a newline or at the byte flagged end_of_file): the line length and a
// keep flag. A line is dropped when it starts with ATOM or HETA, is longer than 66
// bytes and the decimal number from column 60 is below cutoff, with cutoff in
// units of 10^-FRAC_DIGITS. A byte is registered on acceptance and then updates
// the line state, which also loads a finished line into the decision stage; from
// there the result moves into the output register that drives out_valid. Every
// stage takes a new beat each cycle, so the block sustains one byte per clock
// unless the output side holds a result back. The user must write cutoff
// only while no line result is in flight; the block itself does not enforce this.
module bfactor_line_filter
	import bflf_pkg::*;
#(
	parameter int FRAC_DIGITS = 2,
	parameter int VALUE_BITS  = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [23:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  ch,
	input  logic        end_of_file,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        keep,
	output logic [15:0] line_length
);

	localparam int CW = ((VALUE_BITS > 24) ? VALUE_BITS : 24) + 2;
	localparam logic [VALUE_BITS-1:0] MAG_CAP = {1'b1, {(VALUE_BITS-1){1'b0}}};
	localparam logic [VALUE_BITS-1:0] MAG_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

	logic signed [23:0]    cutoff_q;
	logic signed [24:0]    cutoff_neg_q;

	logic                  valid_s1;
	logic [7:0]            ch_s1;
	logic                  eof_s1;

	logic                  valid_s2;
	line_info_t            info_s2;
	logic [VALUE_BITS-1:0] scaled_s2;

	logic                  out_valid_q;
	logic                  keep_q;
	logic [15:0]           len_q;

	logic                  accept;
	logic                  go_s1;
	logic                  close_s1;
	line_info_t            info_s1;
	logic [VALUE_BITS-1:0] scaled_s1;
	logic                  out_ready;
	logic                  free_s2;
	logic                  move_s2;

	logic signed [CW-1:0]  mag_x;
	logic signed [CW-1:0]  pos_x;
	logic signed [CW-1:0]  cut_x;
	logic signed [CW-1:0]  ncut_x;
	logic                  long_rec;
	logic                  pass_neg;
	logic                  pass_pos;
	logic                  keep_s2;

	// cutoff and its negation, so the negative-value test is a plain compare
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cutoff_q     <= '0;
			cutoff_neg_q <= '0;
		end else if (cfg_we) begin
			cutoff_q     <= cfg_wdata;
			cutoff_neg_q <= -{cfg_wdata[23], cfg_wdata};
		end
	end

	assign out_ready = !out_valid_q || !out_stall;
	assign free_s2   = !valid_s2 || out_ready;
	assign move_s2   = valid_s2 && out_ready;
	// a byte that ends no line never waits on the result side
	assign go_s1     = valid_s1 && (!close_s1 || free_s2);
	assign in_stall  = valid_s1 && !go_s1;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ch_s1  <= ch;
			eof_s1 <= end_of_file;
		end
	end

	bflf_line_state #(
		.FRAC_DIGITS(FRAC_DIGITS),
		.VALUE_BITS (VALUE_BITS)
	) u_line_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go_s1),
		.ch        (ch_s1),
		.eof       (eof_s1),
		.close_line(close_s1),
		.info      (info_s1),
		.scaled    (scaled_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go_s1 && close_s1) begin
			valid_s2 <= 1'b1;
		end else if (move_s2) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1 && close_s1) begin
			info_s2   <= info_s1;
			scaled_s2 <= scaled_s1;
		end
	end

	// decide the line: value is -(m, rounded up if digits were dropped) or
	// min(m, MAG_MAX)
	assign mag_x  = {{(CW-VALUE_BITS){1'b0}}, scaled_s2};
	assign pos_x  = {{(CW-VALUE_BITS){1'b0}},
		(scaled_s2 == MAG_CAP) ? MAG_MAX : scaled_s2};
	assign cut_x  = {{(CW-24){cutoff_q[23]}}, cutoff_q};
	assign ncut_x = {{(CW-25){cutoff_neg_q[24]}}, cutoff_neg_q};

	assign long_rec = (info_s2.col > MIN_LONG_LEN) && (info_s2.match != 2'b00);
	assign pass_neg = (info_s2.dropped && scaled_s2 != MAG_CAP) ? (mag_x < ncut_x)
		: (mag_x <= ncut_x);
	assign pass_pos = (pos_x >= cut_x);
	assign keep_s2  = !long_rec || (info_s2.negative ? pass_neg : pass_pos);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s2) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s2) begin
			keep_q <= keep_s2;
			len_q  <= info_s2.col;
		end
	end

	assign out_valid   = out_valid_q;
	assign keep        = keep_q;
	assign line_length = len_q;

	`BFLF_ASSERT_IMPL(a_stall_cause, in_stall,
		valid_s1 && close_s1 && valid_s2 && out_valid_q && out_stall,
		"input stalled without a full result path")
	`BFLF_ASSERT_NEXT(a_result_follows, move_s2, out_valid_q && len_q == $past(info_s2.col),
		"line result not loaded into the output register")
	`BFLF_ASSERT_IMPL(a_short_keep, out_valid_q && len_q <= MIN_LONG_LEN, keep_q,
		"short line dropped")

endmodule

@@ src/bflf_line_state.sv @@
// Per-line parser state: column, record name match and the decimal value.
// Depends on bflf_pkg and bfactor_line_filter_assert.svh.
`include "bfactor_line_filter_assert.svh"

module bflf_line_state
	import bflf_pkg::*;
#(
	parameter int FRAC_DIGITS = 2,
	parameter int VALUE_BITS  = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go,
	input  logic [7:0]            ch,
	input  logic                  eof,
	output logic                  close_line,
	output line_info_t            info,
	output logic [VALUE_BITS-1:0] scaled
);

	localparam int SW = VALUE_BITS + 4;
	localparam logic [VALUE_BITS-1:0] MAG_CAP = {1'b1, {(VALUE_BITS-1){1'b0}}};

	// scaled_q is the magnitude already multiplied up to FRAC_DIGITS fraction
	// digits, saturated at MAG_CAP
	logic [15:0]           col_q;
	logic [1:0]            match_q;
	phase_t                phase_q;
	logic                  neg_q;
	logic [VALUE_BITS-1:0] scaled_q;
	logic [2:0]            frac_cnt_q;
	logic                  dropped_q;

	logic [15:0]           col_n;
	logic [1:0]            match_n;
	phase_t                phase_n;
	phase_t                phase_eff;
	logic                  neg_n;
	logic [VALUE_BITS-1:0] scaled_n;
	logic [2:0]            frac_cnt_n;
	logic                  dropped_n;

	logic                  is_nl;
	logic                  is_digit;
	logic                  is_blank;
	logic [3:0]            digit;
	logic                  num_step;
	logic [2:0]            w_idx;
	logic [SW-1:0]         int_sum;
	logic [SW-1:0]         frac_sum;

	assign is_nl      = (ch == CH_NL);
	assign is_digit   = (ch inside {[CH_0:CH_9]});
	assign is_blank   = (ch inside {CH_SP, CH_TAB, CH_VT, CH_FF, CH_CR});
	assign digit      = ch[3:0];
	assign close_line = is_nl || eof;

	assign w_idx    = 3'(FRAC_DIGITS - 1) - frac_cnt_q;
	assign int_sum  = ({4'b0, scaled_q} << 3) + ({4'b0, scaled_q} << 1)
		+ SW'(digit * POW10[FRAC_DIGITS]);
	assign frac_sum = {4'b0, scaled_q} + SW'(digit * POW10[w_idx]);

	always_comb begin
		col_n      = col_q;
		match_n    = match_q;
		phase_n    = phase_q;
		neg_n      = neg_q;
		scaled_n   = scaled_q;
		frac_cnt_n = frac_cnt_q;
		dropped_n  = dropped_q;
		num_step   = 1'b0;
		phase_eff  = phase_q;

		// a newline closes the line without being counted
		if (!is_nl) begin
			if (col_q < 16'd4) begin
				if (ch != PAT_ATOM[col_q[1:0]]) begin
					match_n[0] = 1'b0;
				end
				if (ch != PAT_HETA[col_q[1:0]]) begin
					match_n[1] = 1'b0;
				end
			end

			if (phase_q == PH_WAIT && col_q == COL_START) begin
				phase_eff = PH_LEAD;
			end
			phase_n = phase_eff;

			case (phase_eff)
				PH_LEAD: begin
					if (is_blank) begin
						phase_n = PH_LEAD;
					end else if (ch == CH_PLUS || ch == CH_MINUS) begin
						neg_n   = (ch == CH_MINUS);
						phase_n = PH_SIGNED;
					end else begin
						num_step = 1'b1;
					end
				end
				PH_SIGNED, PH_INT: begin
					num_step = 1'b1;
				end
				PH_FRAC: begin
					if (!is_digit) begin
						phase_n = PH_DONE;
					end else if (frac_cnt_q < 3'(FRAC_DIGITS)) begin
						frac_cnt_n = frac_cnt_q + 3'd1;
						scaled_n   = (frac_sum > {4'b0, MAG_CAP}) ? MAG_CAP
							: frac_sum[VALUE_BITS-1:0];
					end else if (digit != 4'd0) begin
						// drop the digit, remember it for floor rounding
						dropped_n = 1'b1;
					end
				end
				default: begin
				end
			endcase

			if (num_step) begin
				if (is_digit) begin
					scaled_n = (int_sum > {4'b0, MAG_CAP}) ? MAG_CAP
						: int_sum[VALUE_BITS-1:0];
					phase_n  = PH_INT;
				end else if (ch == CH_POINT) begin
					phase_n = PH_FRAC;
				end else begin
					phase_n = PH_DONE;
				end
			end

			if (col_q != COL_MAX) begin
				col_n = col_q + 16'd1;
			end
		end
	end

	assign info   = '{col: col_n, match: match_n, negative: neg_n, dropped: dropped_n};
	assign scaled = scaled_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			match_q    <= 2'b11;
			phase_q    <= PH_WAIT;
			neg_q      <= 1'b0;
			scaled_q   <= '0;
			frac_cnt_q <= '0;
			dropped_q  <= 1'b0;
		end else if (go) begin
			if (close_line) begin
				col_q      <= '0;
				match_q    <= 2'b11;
				phase_q    <= PH_WAIT;
				neg_q      <= 1'b0;
				scaled_q   <= '0;
				frac_cnt_q <= '0;
				dropped_q  <= 1'b0;
			end else begin
				col_q      <= col_n;
				match_q    <= match_n;
				phase_q    <= phase_n;
				neg_q      <= neg_n;
				scaled_q   <= scaled_n;
				frac_cnt_q <= frac_cnt_n;
				dropped_q  <= dropped_n;
			end
		end
	end

	`BFLF_ASSERT_ALWAYS(a_scaled_cap, scaled_q <= MAG_CAP, "scaled value above saturation cap")
	`BFLF_ASSERT_ALWAYS(a_frac_cnt, frac_cnt_q <= 3'(FRAC_DIGITS), "fraction count overrun")
	`BFLF_ASSERT_NEXT(a_line_clear, go && close_line,
		col_q == 16'd0 && phase_q == PH_WAIT && match_q == 2'b11, "line state not cleared")

endmodule
